// ===== sv/lzsd_pkg.sv =====
// Package for the LZSS stream decompressor: word structs, history geometry,
// status codes and sequencer enums. No dependencies.
package lzsd_pkg;

  localparam int unsigned HIST_DEPTH = 4096;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned MIN_MATCH  = 3;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned CFG_AW     = 3;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_TRUNC = 3'd1,
    ST_PAD   = 3'd2,
    ST_TRAIL = 3'd3,
    ST_DIST  = 3'd4,
    ST_OVER  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    PH_FLAG  = 3'd0,
    PH_LIT   = 3'd1,
    PH_MLO   = 3'd2,
    PH_MHI   = 3'd3,
    PH_DRAIN = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_EXEC = 3'd1,
    S_RD   = 3'd2,
    S_CPY  = 3'd3,
    S_STAT = 3'd4
  } seq_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    status_t    status_code;
    logic       run_last;
  } out_word_t;

  // History write port
  typedef struct packed {
    logic               en;
    logic [HIST_AW-1:0] addr;
    logic [7:0]         data;
  } hist_wr_t;

endpackage

// ===== sv/lzss_stream_decompressor_top.sv =====
// Top level of the LZSS stream decompressor: APB register, token sequencer,
// output register. Depends on lzsd_pkg and lzsd_hist.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall   in_data   (in_word_t)
//   out      source     out_valid / out_stall out_data  (out_word_t)
//   cfg      APB slave  psel/penable/pready   pwdata/prdata, paddr
//
// Each input byte is taken in S_IDLE and worked on in S_EXEC. A match word
// then replays its bytes, since each byte goes through one read of the history
// RAM (S_RD) and one write (S_CPY); a status word is loaded in S_STAT. in_stall
// is high from acceptance until the word's last result is loaded into the
// output register; out_stall holds the sequencer.
// rst_n is synchronous and clears the sequencer, counters and register;
// the history RAM is not cleared.
module lzss_stream_decompressor_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lzsd_pkg::in_word_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lzsd_pkg::out_word_t        out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lzsd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import lzsd_pkg::*;

  typedef struct packed {
    logic    hit;
    status_t code;
    phase_t  phase;
  } settle_t;

  // Check output completion after a token or flag byte, or pick the next phase
  function automatic settle_t settle(logic [31:0] pc, logic [31:0] exp_len,
                                     logic [3:0] slot, logic [7:0] flags,
                                     logic end_i);
    settle_t s;
    logic    pad;
    s.hit   = 1'b0;
    s.code  = ST_OK;
    s.phase = PH_FLAG;
    pad = !slot[3] && ((flags >> slot[2:0]) != 8'd0);
    if (pc >= exp_len) begin
      s.hit  = 1'b1;
      s.code = pad ? ST_PAD : (end_i ? ST_OK : ST_TRAIL);
    end else if (end_i) begin
      s.hit  = 1'b1;
      s.code = ST_TRUNC;
    end else if (slot[3]) begin
      s.phase = PH_FLAG;
    end else begin
      s.phase = flags[slot[2:0]] ? PH_LIT : PH_MLO;
    end
    return s;
  endfunction

  seq_t               state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic               end_r, end_nxt;
  logic [HIST_AW-1:0] hp_r, hp_nxt;
  logic [31:0]        pc_r, pc_nxt;
  logic [7:0]         flags_r, flags_nxt;
  logic [3:0]         slot_r, slot_nxt;
  logic [7:0]         mlb_r, mlb_nxt;
  logic [HIST_AW-1:0] dist_r, dist_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  status_t            code_r, code_nxt;
  logic [31:0]        exp_r;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_data_r, out_data_nxt;

  hist_wr_t           hist_wr;
  logic               rd_en;
  logic [HIST_AW-1:0] rd_addr;
  logic [7:0]         rd_data;

  logic               out_free;
  logic               cfg_wr;
  settle_t            s_tok;
  settle_t            s_flag;
  logic [HIST_AW:0]   dist_full;
  logic [LEN_W-1:0]   len_full;
  logic [31:0]        avail;
  logic [31:0]        pc_inc;
  logic [3:0]         slot_inc;

  lzsd_hist u_hist (
    .clk     (clk),
    .wr      (hist_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Configuration register
  assign cfg_wr = psel && penable && pwrite && !paddr[CFG_AW-1];
  assign pready = 1'b1;
  assign prdata = paddr[CFG_AW-1] ? 32'd0 : exp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= 32'd0;
    end else if (cfg_wr) begin
      exp_r <= pwdata;
    end
  end

  // Shared decode terms
  assign out_free  = !out_valid_r || !out_stall;
  assign pc_inc    = pc_r + 32'd1;
  assign slot_inc  = slot_r + 4'd1;
  assign s_tok     = settle(pc_inc, exp_r, slot_inc, flags_r, end_r);
  assign s_flag    = settle(pc_r, exp_r, 4'd0, byte_r, end_r);
  assign dist_full = {1'b0, byte_r, mlb_r[7:4]} + (HIST_AW + 1)'(1);
  assign len_full  = LEN_W'(mlb_r[3:0]) + LEN_W'(MIN_MATCH);
  assign avail     = exp_r - pc_r;
  assign rd_addr   = hp_r - dist_r;
  assign rd_en     = (state_r == S_RD);

  // Sequencer next state and outputs
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    byte_nxt      = byte_r;
    end_nxt       = end_r;
    hp_nxt        = hp_r;
    pc_nxt        = pc_r;
    flags_nxt     = flags_r;
    slot_nxt      = slot_r;
    mlb_nxt       = mlb_r;
    dist_nxt      = dist_r;
    rem_nxt       = rem_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    hist_wr.en    = 1'b0;
    hist_wr.addr  = hp_r;
    hist_wr.data  = byte_r;
    in_stall      = (state_r != S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt  = in_data.in_byte;
          end_nxt   = in_data.stream_end;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (phase_r)
          PH_FLAG: begin
            if (pc_r >= exp_r) begin
              code_nxt  = ST_TRAIL;
              state_nxt = S_STAT;
            end else begin
              flags_nxt = byte_r;
              slot_nxt  = 4'd0;
              if (s_flag.hit) begin
                code_nxt  = s_flag.code;
                state_nxt = S_STAT;
              end else begin
                phase_nxt = s_flag.phase;
                state_nxt = S_IDLE;
              end
            end
          end

          PH_LIT: begin
            if (out_free) begin
              hist_wr.en             = 1'b1;
              hist_wr.data           = byte_r;
              hp_nxt                 = hp_r + HIST_AW'(1);
              pc_nxt                 = pc_inc;
              slot_nxt               = slot_inc;
              out_valid_nxt          = 1'b1;
              out_data_nxt.kind      = 1'b0;
              out_data_nxt.data_byte = byte_r;
              out_data_nxt.status_code = ST_OK;
              out_data_nxt.run_last  = !s_tok.hit;
              if (s_tok.hit) begin
                code_nxt  = s_tok.code;
                state_nxt = S_STAT;
              end else begin
                phase_nxt = s_tok.phase;
                state_nxt = S_IDLE;
              end
            end
          end

          PH_MLO: begin
            mlb_nxt   = byte_r;
            phase_nxt = PH_MHI;
            if (end_r) begin
              code_nxt  = ST_TRUNC;
              state_nxt = S_STAT;
            end else begin
              state_nxt = S_IDLE;
            end
          end

          PH_MHI: begin
            if (32'(dist_full) > pc_r) begin
              code_nxt  = ST_DIST;
              state_nxt = S_STAT;
            end else if (pc_r >= exp_r || 32'(len_full) > avail) begin
              code_nxt  = ST_OVER;
              state_nxt = S_STAT;
            end else begin
              dist_nxt  = dist_full[HIST_AW-1:0];
              rem_nxt   = len_full;
              state_nxt = S_RD;
            end
          end

          PH_DRAIN: begin
            if (end_r) begin
              hp_nxt    = '0;
              pc_nxt    = 32'd0;
              flags_nxt = 8'd0;
              slot_nxt  = 4'd8;
              mlb_nxt   = 8'd0;
              phase_nxt = PH_FLAG;
            end
            state_nxt = S_IDLE;
          end

          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      // Issue the history read for the next replayed byte
      S_RD: begin
        state_nxt = S_CPY;
      end

      // Emit the replayed byte and append it to the history
      S_CPY: begin
        if (out_free) begin
          hist_wr.en               = 1'b1;
          hist_wr.data             = rd_data;
          hp_nxt                   = hp_r + HIST_AW'(1);
          pc_nxt                   = pc_inc;
          rem_nxt                  = rem_r - LEN_W'(1);
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind        = 1'b0;
          out_data_nxt.data_byte   = rd_data;
          out_data_nxt.status_code = ST_OK;
          out_data_nxt.run_last    = 1'b0;
          if (rem_r == LEN_W'(1)) begin
            slot_nxt              = slot_inc;
            out_data_nxt.run_last = !s_tok.hit;
            if (s_tok.hit) begin
              code_nxt  = s_tok.code;
              state_nxt = S_STAT;
            end else begin
              phase_nxt = s_tok.phase;
              state_nxt = S_IDLE;
            end
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      // Report stream status, then restart or drop bytes to the end
      S_STAT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind        = 1'b1;
          out_data_nxt.data_byte   = 8'd0;
          out_data_nxt.status_code = code_r;
          out_data_nxt.run_last    = 1'b1;
          if (end_r) begin
            hp_nxt    = '0;
            pc_nxt    = 32'd0;
            flags_nxt = 8'd0;
            slot_nxt  = 4'd8;
            mlb_nxt   = 8'd0;
            phase_nxt = PH_FLAG;
          end else begin
            phase_nxt = PH_DRAIN;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_FLAG;
      hp_r        <= '0;
      pc_r        <= 32'd0;
      flags_r     <= 8'd0;
      slot_r      <= 4'd8;
      mlb_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      hp_r        <= hp_nxt;
      pc_r        <= pc_nxt;
      flags_r     <= flags_nxt;
      slot_r      <= slot_nxt;
      mlb_r       <= mlb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    end_r      <= end_nxt;
    dist_r     <= dist_nxt;
    rem_r      <= rem_nxt;
    code_r     <= code_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/lzsd_hist.sv =====
// History buffer of the LZSS decompressor: one write port, one read port
// with registered read data. Depends on lzsd_pkg.
module lzsd_hist (
  input  logic                        clk,
  input  lzsd_pkg::hist_wr_t          wr,
  input  logic                        rd_en,
  input  logic [lzsd_pkg::HIST_AW-1:0] rd_addr,
  output logic [7:0]                  rd_data
);
  import lzsd_pkg::*;

  logic [7:0] mem [HIST_DEPTH];
  logic [7:0] rd_data_r;

  // Write the emitted byte
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== tb/lzss_stream_decompressor_top_tb.sv =====
// Testbench for lzss_stream_decompressor_top: directed streams, then random streams
// with and without flaws under several idle and stall mixes, checked by a scoreboard.
// Depends on lzsd_pkg and the decompressor RTL.
module lzss_stream_decompressor_top_tb;
  import lzsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned IDLE_GAP = 16;
  localparam int NO_STATUS = -1;
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam logic [CFG_AW-1:0] ADDR_EXPECTED_LEN = '0;
  localparam int unsigned MAX_MATCH = MIN_MATCH + 15;

  typedef enum int {
    FLAW_NONE, FLAW_SHORT, FLAW_PAD, FLAW_TRAIL, FLAW_FAR, FLAW_OVER, FLAW_NOISE
  } flaw_t;

  // Predicts decompressor output words and checks them in order
  class lzss_scoreboard;
    logic [7:0]         hist [HIST_DEPTH];
    logic [HIST_AW-1:0] hist_ptr;
    logic [31:0]        produced;
    logic [31:0]        exp_len;
    logic [7:0]         flags;
    int unsigned        slot;
    logic [7:0]         match_lo;
    phase_t             phase;
    out_word_t          pending_words[$];
    int unsigned        errors;

    function void restart();
      hist_ptr = '0;
      produced = '0;
      flags = '0;
      slot = 8;
      match_lo = '0;
      phase = PH_FLAG;
    endfunction

    function void power_on();
      exp_len = '0;
      errors = 0;
      pending_words.delete();
      restart();
    endfunction

    function void set_length(logic [31:0] v);
      exp_len = v;
    endfunction

    function int unsigned pending();
      return pending_words.size();
    endfunction

    // Record a byte in history and expect it on the output
    function void emit_data(logic [7:0] b);
      out_word_t w;
      hist[hist_ptr] = b;
      hist_ptr++;
      produced++;
      w = '{kind: KIND_DATA, data_byte: b, status_code: ST_OK, run_last: 1'b0};
      pending_words.push_back(w);
    endfunction

    // Decide the stream outcome after a token or flag byte, or pick the next phase
    function int check_done(bit fin);
      if (produced >= exp_len) begin
        if (slot < 8 && (flags >> slot) != 0) return ST_PAD;
        return fin ? ST_OK : ST_TRAIL;
      end
      if (fin) return ST_TRUNC;
      if (slot >= 8) phase = PH_FLAG;
      else phase = flags[slot] ? PH_LIT : PH_MLO;
      return NO_STATUS;
    endfunction

    function void absorb_byte(in_word_t w);
      int          code;
      int unsigned n0;
      logic [31:0] distance;
      logic [31:0] len;
      logic [15:0] token;
      out_word_t   s;
      n0 = pending_words.size();
      code = NO_STATUS;
      case (phase)
        PH_FLAG: begin
          if (produced >= exp_len) begin
            code = ST_TRAIL;
          end else begin
            flags = w.in_byte;
            slot = 0;
            code = check_done(w.stream_end);
          end
        end
        PH_LIT: begin
          emit_data(w.in_byte);
          slot++;
          code = check_done(w.stream_end);
        end
        PH_MLO: begin
          match_lo = w.in_byte;
          phase = PH_MHI;
          if (w.stream_end) code = ST_TRUNC;
        end
        PH_MHI: begin
          token = {w.in_byte, match_lo};
          distance = 32'(token[15:4]) + 1;
          len = 32'(token[3:0]) + MIN_MATCH;
          if (distance > produced) begin
            code = ST_DIST;
          end else if (produced >= exp_len || len > exp_len - produced) begin
            code = ST_OVER;
          end else begin
            for (int unsigned k = 0; k < len; k++) begin
              emit_data(hist[hist_ptr - distance[HIST_AW-1:0]]);
            end
            slot++;
            code = check_done(w.stream_end);
          end
        end
        default: begin
          // drop until the stream ends
          if (w.stream_end) restart();
          return;
        end
      endcase
      if (code != NO_STATUS) begin
        s = '{kind: KIND_STATUS, data_byte: 8'h00, status_code: status_t'(code),
              run_last: 1'b0};
        pending_words.push_back(s);
        if (w.stream_end) restart();
        else phase = PH_DRAIN;
      end
      // mark the last word caused by this byte
      if (pending_words.size() > n0) begin
        s = pending_words.pop_back();
        s.run_last = 1'b1;
        pending_words.push_back(s);
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (pending_words.size() == 0) begin
        $error("unexpected word: kind %0d data_byte %0h status_code %0d run_last %0d",
               got.kind, got.data_byte, got.status_code, got.run_last);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.data_byte !== want.data_byte) begin
        $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
        errors++;
      end
      if (got.status_code !== want.status_code) begin
        $error("status_code: expected %0d, got %0d", want.status_code, got.status_code);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_word_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_word_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  lzss_scoreboard sb = new;
  int unsigned    src_idle_pct = 0;
  int unsigned    sink_stall_pct = 0;
  int unsigned    items_sent = 0;
  logic [7:0]     stream_bytes[$];

  lzss_stream_decompressor_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_data);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // Offer one compressed byte and hold it until accepted
  task automatic push_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{in_byte: b, stream_end: fin};
    do @(posedge clk); while (in_stall);
    sb.absorb_byte(in_data);
    items_sent++;
  endtask

  task automatic send_stream(input bit close);
    foreach (stream_bytes[i]) push_byte(stream_bytes[i], close && i == stream_bytes.size() - 1);
  endtask

  // Drain all expected words, then let dropped bytes finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic write_expected_length(input logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_EXPECTED_LEN;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_length(v);
  endtask

  // Encode a random stream of the given output length, with an optional flaw
  task automatic build_stream(input int unsigned total, input flaw_t flaw);
    logic [7:0]  grp[$];
    logic [7:0]  flag;
    logic [15:0] token;
    int unsigned made;
    int unsigned rem;
    int unsigned distance;
    int unsigned len;
    int unsigned slot;
    int unsigned cut;
    bit          flawed;
    stream_bytes.delete();
    made = 0;
    flawed = 1'b0;
    if (flaw == FLAW_NOISE || total == 0) begin
      repeat ($urandom_range(1, 6)) stream_bytes.push_back(8'($urandom));
      return;
    end
    while (made < total) begin
      flag = '0;
      grp.delete();
      slot = 0;
      while (slot < 8 && made < total) begin
        rem = total - made;
        if (flaw == FLAW_FAR && !flawed && 2 * made >= total) begin
          distance = made + 1 + $urandom_range(0, HIST_DEPTH - 1 - made);
          len = $urandom_range(MIN_MATCH, MAX_MATCH);
          flawed = 1'b1;
          made += (len < rem) ? len : rem;
        end else if (flaw == FLAW_OVER && !flawed && made > 0 && rem < MAX_MATCH) begin
          len = $urandom_range(rem + 1, MAX_MATCH);
          distance = $urandom_range(1, made);
          flawed = 1'b1;
          made = total;
        end else if (made == 0 || rem < MIN_MATCH || $urandom_range(0, 1) == 0) begin
          flag[slot] = 1'b1;
          grp.push_back(8'($urandom));
          made++;
          distance = 0;
        end else begin
          distance = $urandom_range(1, (made > HIST_DEPTH) ? HIST_DEPTH : made);
          len = $urandom_range(MIN_MATCH, (rem < MAX_MATCH) ? rem : MAX_MATCH);
          made += len;
        end
        // a match token is little endian: distance-1 high, length-MIN_MATCH low
        if (!flag[slot]) begin
          token = 16'(((distance - 1) << 4) | (len - MIN_MATCH));
          grp.push_back(token[7:0]);
          grp.push_back(token[15:8]);
        end
        slot++;
      end
      if (flaw == FLAW_PAD && made >= total && slot < 8) begin
        flag[$urandom_range(slot, 7)] = 1'b1;
        flag |= 8'($urandom) & (8'hFF << slot);
      end
      stream_bytes.push_back(flag);
      foreach (grp[i]) stream_bytes.push_back(grp[i]);
    end
    if (flaw == FLAW_TRAIL) begin
      repeat ($urandom_range(1, 3)) stream_bytes.push_back(8'($urandom));
    end
    if (flaw == FLAW_SHORT && stream_bytes.size() > 1) begin
      cut = $urandom_range(1, stream_bytes.size() - 1);
      while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned pick;
    logic [31:0] len_now;
    flaw_t       flaw;
    sb.power_on();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero expected length: every first byte is trailing
    write_expected_length(32'h0000_0000);
    stream_bytes = '{8'h00};
    send_stream(1'b1);
    stream_bytes = '{8'hFF, 8'h12, 8'h34};
    send_stream(1'b1);

    // Largest length: literals at both byte extremes, then an early end
    wait_idle();
    write_expected_length(32'hFFFF_FFFF);
    stream_bytes = '{8'hFF, 8'h00, 8'hFF};
    send_stream(1'b1);

    // Clean stream with the longest match, then a match before the start
    wait_idle();
    write_expected_length(32'd21);
    stream_bytes = '{8'h0D, 8'hA5, 8'h0F, 8'h00, 8'h5A, 8'hC3};
    send_stream(1'b1);
    stream_bytes = '{8'h00, 8'hFF, 8'hFF};
    send_stream(1'b1);

    // Unused flag bit set once output is complete
    wait_idle();
    write_expected_length(32'd1);
    stream_bytes = '{8'h03, 8'h11};
    send_stream(1'b1);

    // Match longer than the remaining output
    wait_idle();
    write_expected_length(32'd4);
    stream_bytes = '{8'h01, 8'h22, 8'h0F, 8'h00};
    send_stream(1'b1);

    // Lower the length mid-stream below what is already produced
    wait_idle();
    write_expected_length(32'd10);
    stream_bytes = '{8'hFF, 8'h01, 8'h02, 8'h03};
    send_stream(1'b0);
    wait_idle();
    write_expected_length(32'd2);
    stream_bytes = '{8'h04, 8'h00};
    send_stream(1'b1);

    // Random streams under each idle and stall mix
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 61;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 61;
        end
        default: begin
          src_idle_pct = 20;
          sink_stall_pct = 20;
        end
      endcase
      target = items_sent + 72;
      while (items_sent < target) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) len_now = 0;
        else if (pick < 3) len_now = $urandom_range(60, 300);
        else len_now = $urandom_range(1, 40);
        wait_idle();
        write_expected_length(len_now);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 99) < 60) flaw = FLAW_NONE;
          else flaw = flaw_t'($urandom_range(FLAW_SHORT, FLAW_NOISE));
          build_stream(len_now, flaw);
          send_stream(1'b1);
        end
      end
    end

    wait_idle();
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
